// File: hdl/hmas_pkg.sv
// Package for the histogram mode and sum block: field widths, default
// parameters and the control group passed to the scan unit.
// No dependencies.
`default_nettype none

package hmas_pkg;

    localparam int VALUE_W        = 14;
    localparam int SUM_W          = 34;
    localparam int OUT_COUNT_W    = 20;
    localparam int DEF_BINS       = 16384;
    localparam int DEF_COUNT_BITS = 20;

    typedef struct packed {
        logic clr;   // start of a new scan: drop the old best
        logic dv;    // read data from the bin store is valid this cycle
    } t_scan_ctl;

endpackage

`default_nettype wire

// File: hdl/hmas_bin_ram.sv
// Histogram bin store: single-clock memory, one write and one read port,
// registered read data, read-first on a same-address collision.
// Depends on nothing.
`default_nettype none

module hmas_bin_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 20,
    parameter int AW    = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/hmas_mode_scan.sv
// Running maximum over bins read in ascending order; strict compare keeps
// the lowest index on ties.
// Depends on hmas_pkg.
`default_nettype none

module hmas_mode_scan
    import hmas_pkg::*;
#(
    parameter int COUNT_BITS = 20,
    parameter int IDX_W      = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_scan_ctl             i_ctl,
    input  wire logic [COUNT_BITS-1:0] i_count,
    input  wire logic [IDX_W-1:0]      i_idx,
    output logic      [COUNT_BITS-1:0] o_best_count,
    output logic      [IDX_W-1:0]      o_best_idx
);

    logic [COUNT_BITS-1:0] r_best_count;
    logic [IDX_W-1:0]      r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_best_count <= '0;
            r_best_idx   <= '0;
        end else if (i_ctl.dv && (i_count > r_best_count)) begin
            r_best_count <= i_count;
            r_best_idx   <= i_idx;
        end
    end

    assign o_best_count = r_best_count;
    assign o_best_idx   = r_best_idx;

endmodule

`default_nettype wire

// File: hdl/histogram_mode_and_sum.sv
// Histogram mode and sum. Samples are taken one per cycle while o_in_ready is
// high (not while clearing, sweeping or waiting on the output); each bumps
// its bin (read-modify-write through a registered-read bin store, with a
// forwarding register for back-to-back hits on the same bin) and adds to a
// saturating sum. The sample flagged last is counted like the others; then
// input stalls while the store is swept once in ascending order, each bin
// read and cleared in the same cycle through its single read port; the result
// then passes ST_WAIT and ST_DONE. After reset the store is cleared by a sweep
// over all bins during which no sample is taken. The result waits in an
// output register; a new data set may start while it does.
`default_nettype none

module histogram_mode_and_sum
    import hmas_pkg::*;
#(
    parameter int BINS       = DEF_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [VALUE_W-1:0]     i_sample_value,
    input  wire logic                   i_last_sample,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [SUM_W-1:0]       o_total_sum,
    output logic      [VALUE_W-1:0]     o_mode_value,
    output logic      [OUT_COUNT_W-1:0] o_mode_count
);

    localparam int IDX_W = $clog2(BINS);
    localparam int EXT_W = IDX_W + VALUE_W;
    localparam int CXW   = COUNT_BITS + OUT_COUNT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_cnt;
    logic                  cnt_last;

    // stage 1: item whose bin count is being read
    logic                  r_s1_valid, r_s1_inbin, r_s1_last;
    logic [IDX_W-1:0]      r_s1_addr;
    // last write, for a read that collided with it
    logic                  r_fw_valid;
    logic [IDX_W-1:0]      r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;

    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W:0]        sum_add;

    logic                  r_scan_dv;
    logic [IDX_W-1:0]      r_scan_idx;

    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_sum;
    logic [VALUE_W-1:0]    r_out_mode;
    logic [OUT_COUNT_W-1:0] r_out_count;

    logic                  accept, out_free, s1_write, load_out;
    logic [EXT_W-1:0]      sample_ext;
    logic                  sample_inbin;
    logic [COUNT_BITS-1:0] rd_data, cur_count, inc_count;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] best_count;
    logic [IDX_W-1:0]      best_idx;
    logic [EXT_W-1:0]      mode_ext;
    logic [CXW-1:0]        count_ext;
    t_scan_ctl             scan_ctl;

    assign sample_ext   = {{IDX_W{1'b0}}, i_sample_value};
    assign sample_inbin = sample_ext < EXT_W'(BINS);
    assign cnt_last     = r_cnt == IDX_W'(BINS - 1);

    assign o_in_ready = (r_state == ST_RUN) && !(r_s1_valid && r_s1_last);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = (r_state == ST_DONE) && out_free;

    // bin increment with forwarding and saturation
    assign cur_count = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : rd_data;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
    assign s1_write  = r_s1_valid && r_s1_inbin;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_s1_addr;
        ram_wdata = inc_count;
        ram_raddr = sample_ext[IDX_W-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
            end
            ST_SCAN: begin
                // read-first store: the read sees the count, the bin is cleared
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
                ram_raddr = r_cnt;
            end
            ST_RUN: begin
                ram_we = s1_write;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    hmas_bin_ram #(
        .DEPTH (BINS),
        .WIDTH (COUNT_BITS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign scan_ctl.clr = (r_state == ST_RUN) && r_s1_valid && r_s1_last;
    assign scan_ctl.dv  = r_scan_dv;

    hmas_mode_scan #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_count      (rd_data),
        .i_idx        (r_scan_idx),
        .o_best_count (best_count),
        .o_best_idx   (best_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (cnt_last) n_state = ST_RUN;
            ST_RUN:   if (r_s1_valid && r_s1_last) n_state = ST_SCAN;
            ST_SCAN:  if (cnt_last) n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    assign sum_add = {1'b0, r_sum} + {{(SUM_W + 1 - VALUE_W){1'b0}}, i_sample_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_scan_dv   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
                r_cnt <= cnt_last ? '0 : r_cnt + IDX_W'(1);
            end
            r_s1_valid <= accept;
            r_fw_valid <= (r_state == ST_RUN) && s1_write;
            r_scan_dv  <= r_state == ST_SCAN;
            if (accept) begin
                r_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            end else if (load_out) begin
                r_sum <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign mode_ext  = {{VALUE_W{1'b0}}, best_idx};
    assign count_ext = {{OUT_COUNT_W{1'b0}}, best_count};

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= sample_ext[IDX_W-1:0];
            r_s1_inbin <= sample_inbin;
            r_s1_last  <= i_last_sample;
        end
        r_fw_addr  <= r_s1_addr;
        r_fw_data  <= inc_count;
        r_scan_idx <= r_cnt;
        if (load_out) begin
            r_out_sum   <= r_sum;
            r_out_mode  <= mode_ext[VALUE_W-1:0];
            r_out_count <= (count_ext > CXW'({OUT_COUNT_W{1'b1}}))
                           ? {OUT_COUNT_W{1'b1}} : count_ext[OUT_COUNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_total_sum  = r_out_sum;
    assign o_mode_value = r_out_mode;
    assign o_mode_count = r_out_count;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for histogram_mode_and_sum: streams data sets of samples,
// predicts sum / mode / count per set, and compares each result in order.
// Depends on hmas_pkg and the histogram_mode_and_sum top level.
`default_nettype none

module testbench;
    import hmas_pkg::*;

    localparam int unsigned HIST_BINS  = DEF_BINS;
    localparam longint unsigned BIN_CAP = (64'd1 << DEF_COUNT_BITS) - 1;
    localparam longint unsigned OUT_CAP = (64'd1 << OUT_COUNT_W) - 1;
    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;
    localparam int RANDOM_SAMPLES = 850;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               hold;   // wait for all results before sending
    } t_sample_req;

    typedef struct {
        logic [SUM_W-1:0]       total;
        logic [VALUE_W-1:0]     mode;
        logic [OUT_COUNT_W-1:0] count;
    } t_set_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [VALUE_W-1:0] in_value = '0;
    logic in_last = 1'b0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [SUM_W-1:0] o_total_sum;
    logic [VALUE_W-1:0] o_mode_value;
    logic [OUT_COUNT_W-1:0] o_mode_count;

    t_sample_req pending_samples[$];
    t_set_result set_results_due[$];

    // predictor state
    longint unsigned hist_model[int];
    longint unsigned sum_model = 0;

    int errors = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int sets_built = 0;
    int gap_cnt = 0;
    int stall_cnt = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    histogram_mode_and_sum uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (in_value),
        .i_last_sample  (in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_total_sum    (o_total_sum),
        .o_mode_value   (o_mode_value),
        .o_mode_count   (o_mode_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Count one sample; on the last of a set, sweep the bins in ascending
    // order (lowest index wins ties) and queue the expected result.
    task automatic tally_sample(input logic [VALUE_W-1:0] value, input logic last);
        t_set_result res;
        longint unsigned best;
        int best_idx;
        if (int'(value) < HIST_BINS) begin
            if (!hist_model.exists(int'(value)))
                hist_model[int'(value)] = 0;
            if (hist_model[int'(value)] < BIN_CAP)
                hist_model[int'(value)]++;
        end
        if (sum_model > SUM_CAP - value)
            sum_model = SUM_CAP;
        else
            sum_model += value;
        if (last) begin
            best = hist_model.exists(0) ? hist_model[0] : 0;
            best_idx = 0;
            foreach (hist_model[k]) begin
                if (hist_model[k] > best) begin
                    best = hist_model[k];
                    best_idx = k;
                end
            end
            res.total = sum_model[SUM_W-1:0];
            res.mode  = best_idx[VALUE_W-1:0];
            res.count = (best > OUT_CAP) ? OUT_CAP[OUT_COUNT_W-1:0] : best[OUT_COUNT_W-1:0];
            set_results_due.push_back(res);
            hist_model.delete();
            sum_model = 0;
        end
    endtask

    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(50, 400);
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit take;
        int g;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_cnt  <= 0;
        end else begin
            take = in_valid && o_in_ready;
            if (take) begin
                tally_sample(in_value, in_last);
                samples_sent++;
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
            end
            if (!(in_valid && !take)) begin
                g = take ? pick_send_gap() : gap_cnt;
                if (g > 0) begin
                    in_valid <= 1'b0;
                    gap_cnt  <= g - 1;
                end else if (pending_samples.size() > 0 &&
                             !(pending_samples[0].hold && set_results_due.size() > 0)) begin
                    in_value <= pending_samples[0].value;
                    in_last  <= pending_samples[0].last;
                    in_valid <= 1'b1;
                    gap_cnt  <= 0;
                    void'(pending_samples.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side back-pressure
    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (set_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sum=%0d mode=%0d count=%0d",
                                              o_total_sum, o_mode_value, o_mode_count));
                end else begin
                    want = set_results_due.pop_front();
                    if (o_total_sum !== want.total)
                        report_mismatch($sformatf("result %0d total_sum got %0d want %0d",
                                                  results_seen, o_total_sum, want.total));
                    if (o_mode_value !== want.mode)
                        report_mismatch($sformatf("result %0d mode_value got %0d want %0d",
                                                  results_seen, o_mode_value, want.mode));
                    if (o_mode_count !== want.count)
                        report_mismatch($sformatf("result %0d mode_count got %0d want %0d",
                                                  results_seen, o_mode_count, want.count));
                end
            end
            if ($urandom_range(0, 2999) == 0)
                recv_calm = !recv_calm;
            if (stall_cnt > 0) begin
                out_ready <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else if (!recv_calm && $urandom_range(0, 99) < 8) begin
                out_ready <= 1'b0;
                stall_cnt <= pick_stall() - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic add_sample(input int value, input bit last, input bit hold);
        t_sample_req s;
        s.value = value[VALUE_W-1:0];
        s.last  = last;
        s.hold  = hold;
        pending_samples.push_back(s);
        if (last) sets_built++;
    endtask

    initial begin
        int total;
        int len;
        int r;
        int kind;
        int lo;
        int hi;
        int pool[4];
        int v;

        // directed sets
        add_sample(0, 1'b1, 1'b0);                        // single zero
        add_sample(16383, 1'b1, 1'b0);                    // single top value
        add_sample(16383, 1'b0, 1'b0);                    // equal counts: bin 0 wins
        add_sample(0, 1'b1, 1'b0);
        add_sample(9, 1'b0, 1'b1);                        // tie at 2, lower value kept
        add_sample(5, 1'b0, 1'b0);
        add_sample(9, 1'b0, 1'b0);
        add_sample(5, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++) add_sample(16383, 1'b0, 1'b0);
        for (int i = 0; i < 2; i++) add_sample(0, 1'b0, 1'b0);
        add_sample(0, 1'b1, 1'b0);                        // tie between extremes
        add_sample(8191, 1'b0, 1'b0);                     // back-to-back same bin
        add_sample(8191, 1'b0, 1'b0);
        add_sample(8191, 1'b0, 1'b0);
        add_sample(4096, 1'b0, 1'b0);
        add_sample(8191, 1'b1, 1'b0);

        // random sets
        total = 0;
        while (total < RANDOM_SAMPLES) begin
            r = $urandom_range(0, 99);
            if (r < 20)      len = $urandom_range(1, 4);
            else if (r < 80) len = $urandom_range(10, 40);
            else             len = $urandom_range(40, 80);
            kind = $urandom_range(0, 9);
            lo = $urandom_range(0, 16383);
            hi = (lo + 63 > 16383) ? 16383 : lo + 63;
            foreach (pool[k]) begin
                case ($urandom_range(0, 5))
                    0:       pool[k] = 0;
                    1:       pool[k] = 16383;
                    default: pool[k] = $urandom_range(0, 16383);
                endcase
            end
            for (int i = 0; i < len; i++) begin
                if (kind < 4)      v = pool[$urandom_range(0, 3)];
                else if (kind < 7) v = $urandom_range(lo, hi);
                else               v = $urandom_range(0, 16383);
                add_sample(v, i == len - 1, i == 0 && $urandom_range(0, 9) == 0);
            end
            total += len;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() > 0 || in_valid) @(posedge i_clk);
        while (set_results_due.size() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("covered %0d samples in %0d data sets, %0d results checked",
                 samples_sent, sets_built, results_seen);
        $display("sets mixed repeated pools, narrow windows and full-range values");
        if (errors == 0 && set_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // each set costs a full bin sweep; sized for every sample closing a set
    // under the longest stalls, with a wide margin
    initial begin
        #200000000;
        $display("timeout with %0d results outstanding", set_results_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
